// File: hdl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer.
// Screen geometry, character codes, command codes and the item structs.
// No dependencies; imported by every module under hdl/.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int TAB_CELLS = 4;

  // Column counter also holds col+4 before wrap; row counter holds ROWS
  localparam int COL_W  = $clog2(COLUMNS + TAB_CELLS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  // Linear address reaches CELLS+3 during tab writes
  localparam int ADDR_W = $clog2(CELLS + TAB_CELLS);
  localparam int MEM_AW = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Field widths fixed by the interface
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 8;
  localparam int IN_CMP_W  = 9;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] BLANK_CH = 8'h20;
  localparam logic [7:0] MARK_CH  = 8'h45;

  // Configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;
  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_PUT_AT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } tcw_cmd_t;

  typedef struct packed {
    tcw_cmd_t   cmd;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [7:0] col;
    logic [7:0] row;
  } tcw_in_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [7:0]           read_char;
    logic [7:0]           read_attr;
    logic                 range_error;
  } tcw_out_t;

  // Cell store access: one write and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } tcw_mem_req_t;

endpackage

// File: hdl/tcw_cell_store.sv
// tcw_cell_store: screen memory, one character/attribute cell per entry.
// One write port, one read port, read data registered.
// Depends on tcw_pkg.
module tcw_cell_store
  import tcw_pkg::*;
(
  input  logic              clk,
  input  tcw_mem_req_t      req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tcw_engine.sv
// tcw_engine: command sequencer of the text console writer.
// Holds the cursor, decodes each item and walks the cell store for puts,
// reads, scroll, clear and the post-reset blanking pass. Depends on tcw_pkg.
module tcw_engine
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_in_t           in_item,
  input  logic [7:0]        default_attr,
  input  logic [7:0]        error_attr,
  output logic              res_valid,
  input  logic              res_take,
  output tcw_out_t          res_item,
  output tcw_mem_req_t      mem_req,
  input  logic [CELL_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CALC, ST_PUT, ST_TAB, ST_CHECK, ST_SCROLL,
    ST_FILL, ST_CLEAR, ST_MARK, ST_RREQ, ST_RDAT, ST_DONE
  } state_t;

  state_t            state_r;
  tcw_cmd_t          cmd_r;
  logic [7:0]        ch_r;
  logic [7:0]        ea_r;
  logic [ADDR_W-1:0] addr_r;
  logic [1:0]        cnt_r;
  logic [COL_W-1:0]  pos_col_r;
  logic [ROW_W-1:0]  pos_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [7:0]        rd_char_r;
  logic [7:0]        rd_attr_r;
  logic              err_r;

  logic              in_range;
  logic [ADDR_W-1:0] lin_addr;
  logic [COL_W-1:0]  col_tab;

  // bounds check of the item's column and row
  assign in_range = (IN_CMP_W'(in_item.col) < IN_CMP_W'(COLUMNS)) &&
                    (IN_CMP_W'(in_item.row) < IN_CMP_W'(ROWS));

  // linear cell index of the working position
  assign lin_addr = ADDR_W'(pos_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(pos_col_r);
  assign col_tab  = pos_col_r + COL_W'(TAB_CELLS);

  // cell store requests, decoded from the state
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = MEM_AW'(addr_r);
    mem_req.raddr = MEM_AW'(addr_r);
    mem_req.wdata = {ea_r, BLANK_CH};
    case (state_r)
      ST_INIT, ST_CLEAR, ST_FILL: begin
        mem_req.we = 1'b1;
      end
      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = {ea_r, ch_r};
      end
      ST_TAB: begin
        // cells past the end of the screen are dropped
        mem_req.we = (addr_r < ADDR_W'(CELLS));
      end
      ST_MARK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_AW'(CELLS - 1);
        mem_req.wdata = {error_attr, MARK_CH};
      end
      ST_RREQ: begin
        mem_req.re = 1'b1;
      end
      ST_SCROLL: begin
        // read row r+1 ahead, write the registered read data back one row up
        mem_req.re    = (addr_r < ADDR_W'(CELLS));
        mem_req.we    = (addr_r != ADDR_W'(COLUMNS));
        mem_req.waddr = MEM_AW'(addr_r - ADDR_W'(COLUMNS + 1));
        mem_req.wdata = mem_rdata;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      addr_r    <= '0;
      ea_r      <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      case (state_r)
        // blank every cell with attribute zero after reset
        ST_INIT: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == ADDR_W'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_item.cmd;
            ch_r      <= in_item.ch;
            rd_char_r <= '0;
            rd_attr_r <= '0;
            err_r     <= 1'b0;
            addr_r    <= '0;
            cnt_r     <= '0;
            if (in_item.cmd == CMD_CLEAR || in_item.attr != '0) begin
              ea_r <= in_item.attr;
            end else begin
              ea_r <= default_attr;
            end
            if (in_item.cmd == CMD_PUT) begin
              pos_col_r <= cur_col_r;
              pos_row_r <= cur_row_r;
            end else begin
              pos_col_r <= COL_W'(in_item.col);
              pos_row_r <= ROW_W'(in_item.row);
            end
            case (in_item.cmd)
              CMD_CLEAR: begin
                state_r <= ST_CLEAR;
              end
              CMD_READ: begin
                if (in_range) begin
                  state_r <= ST_CALC;
                end else begin
                  err_r   <= 1'b1;
                  state_r <= ST_DONE;
                end
              end
              CMD_PUT_AT: begin
                if (in_range) begin
                  state_r <= ST_CALC;
                end else begin
                  err_r   <= 1'b1;
                  state_r <= ST_MARK;
                end
              end
              default: begin
                state_r <= ST_CALC;
              end
            endcase
          end
        end
        // linear address, then decode the character or start the read
        ST_CALC: begin
          addr_r <= lin_addr;
          if (cmd_r == CMD_READ) begin
            state_r <= ST_RREQ;
          end else begin
            case (ch_r)
              CH_NL: begin
                pos_col_r <= '0;
                pos_row_r <= pos_row_r + 1'b1;
                state_r   <= ST_CHECK;
              end
              CH_CR: begin
                state_r <= ST_CHECK;
              end
              CH_BS: begin
                if (pos_col_r != '0) begin
                  pos_col_r <= pos_col_r - 1'b1;
                end else if (pos_row_r != '0) begin
                  pos_col_r <= COL_W'(COLUMNS - 1);
                  pos_row_r <= pos_row_r - 1'b1;
                end
                state_r <= ST_CHECK;
              end
              CH_TAB: begin
                state_r <= ST_TAB;
              end
              default: begin
                state_r <= ST_PUT;
              end
            endcase
          end
        end
        ST_PUT: begin
          if (pos_col_r == COL_W'(COLUMNS - 1)) begin
            pos_col_r <= '0;
            pos_row_r <= pos_row_r + 1'b1;
          end else begin
            pos_col_r <= pos_col_r + 1'b1;
          end
          state_r <= ST_CHECK;
        end
        // four blanks, one per cycle
        ST_TAB: begin
          addr_r <= addr_r + 1'b1;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 2'(TAB_CELLS - 1)) begin
            if (col_tab >= COL_W'(COLUMNS)) begin
              pos_col_r <= col_tab - COL_W'(COLUMNS);
              pos_row_r <= pos_row_r + 1'b1;
            end else begin
              pos_col_r <= col_tab;
            end
            state_r <= ST_CHECK;
          end
        end
        // past the last row: scroll up one row; else commit the cursor
        ST_CHECK: begin
          if (pos_row_r == ROW_W'(ROWS)) begin
            pos_row_r <= ROW_W'(ROWS - 1);
            addr_r    <= ADDR_W'(COLUMNS);
            state_r   <= ST_SCROLL;
          end else begin
            cur_col_r <= pos_col_r;
            cur_row_r <= pos_row_r;
            state_r   <= ST_DONE;
          end
        end
        ST_SCROLL: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == ADDR_W'(CELLS)) begin
            addr_r  <= ADDR_W'(CELLS - COLUMNS);
            state_r <= ST_FILL;
          end
        end
        // blank the new bottom row
        ST_FILL: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == ADDR_W'(CELLS - 1)) begin
            cur_col_r <= pos_col_r;
            cur_row_r <= pos_row_r;
            state_r   <= ST_DONE;
          end
        end
        ST_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == ADDR_W'(CELLS - 1)) begin
            cur_col_r <= '0;
            cur_row_r <= '0;
            state_r   <= ST_DONE;
          end
        end
        ST_MARK: begin
          state_r <= ST_DONE;
        end
        ST_RREQ: begin
          state_r <= ST_RDAT;
        end
        ST_RDAT: begin
          rd_char_r <= mem_rdata[7:0];
          rd_attr_r <= mem_rdata[15:8];
          state_r   <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res_item.cursor_col  = CUR_COL_W'(cur_col_r);
    res_item.cursor_row  = CUR_ROW_W'(cur_row_r);
    res_item.read_char   = rd_char_r;
    res_item.read_attr   = rd_attr_r;
    res_item.range_error = err_r;
  end

endmodule

// File: hdl/text_console_writer.sv
// text_console_writer: 80x25 text console, one result item per command item.
// Each item is taken alone: the engine decodes it and walks the cell store, whose
// single write port carries puts, tabs, scrolls and clears; the result then waits
// for the output register. One item in flight: in_ready stays low until the result
// is taken, so a stalled output also holds off the next item.
// Reset: sync, active low; a blanking pass over every cell follows, in_ready low.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcw_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcw_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  logic [7:0]        default_attr_r;
  logic [7:0]        error_attr_r;
  logic              out_valid_r;
  tcw_out_t          out_item_r;
  logic              res_valid;
  logic              res_take;
  tcw_out_t          res_item;
  tcw_mem_req_t      mem_req;
  logic [CELL_W-1:0] mem_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= DEFAULT_ATTR_RST;
      error_attr_r   <= ERROR_ATTR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_ATTR: default_attr_r <= cfg_data;
        REG_ERROR_ATTR:   error_attr_r   <= cfg_data;
        default: begin
          default_attr_r <= default_attr_r;
        end
      endcase
    end
  end

  tcw_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .default_attr (default_attr_r),
    .error_attr   (error_attr_r),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_item     (res_item),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  tcw_cell_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // one item in the engine at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while engine busy");

  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_item.cursor_row) < ROWS))
    else $error("cursor row out of range");

  a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_item.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

endmodule
